[rtl/rbds_pkg.sv]
// Shared types and constants for the RGBA box-filter downsampler.
// No dependencies; rbds_div and the top level use this package.
package rbds_pkg;

  localparam int PIX_W   = 32;
  localparam int CH_W    = 8;
  localparam int NUM_CH  = 4;
  localparam int BLK_REG_W = 5;
  localparam int WID_REG_W = 13;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 13;

  localparam logic [CFG_IDX_W-1:0] CFG_OVERSAMPLE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_WIDTH  = 2'd2;

  localparam logic [BLK_REG_W-1:0] BLOCK_RESET = 5'd2;
  localparam logic [WID_REG_W-1:0] WIDTH_RESET = 13'd1024;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RMW,
    ST_DIV
  } state_t;

endpackage

[rtl/rbds_line_store.sv]
// Line store of per-column channel sums: one write and one registered read port.
// Depends on nothing but its parameters.
module rbds_line_store #(
  parameter int DEPTH  = 4096,
  parameter int DATA_W = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [DATA_W-1:0]        wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [DATA_W-1:0]        rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[rtl/rbds_div.sv]
// Four-lane restoring divider, one quotient bit per cycle, 8-bit quotients.
// Uses rbds_pkg for channel count and width.
module rbds_div #(
  parameter int SUM_W = 16,
  parameter int N_W   = 10
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  logic [rbds_pkg::NUM_CH*SUM_W-1:0]    sums,
  input  logic [N_W-1:0]                       divisor,
  output logic                                 done,
  output logic [rbds_pkg::NUM_CH*rbds_pkg::CH_W-1:0] quot
);

  localparam int WIDE_W = SUM_W + rbds_pkg::CH_W;

  logic [SUM_W-1:0] rem [rbds_pkg::NUM_CH];
  logic [N_W-1:0]   dvs;
  logic [2:0]       bitpos;
  logic             busy;
  logic [WIDE_W-1:0] shifted;

  assign shifted = WIDE_W'(dvs) << bitpos;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      bitpos <= 3'd7;
    end else begin
      done <= busy && (bitpos == 3'd0);
      if (start) begin
        busy <= 1'b1;
        bitpos <= 3'd7;
      end else if (busy) begin
        bitpos <= bitpos - 3'd1;
        if (bitpos == 3'd0) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvs <= divisor;
      for (int c = 0; c < rbds_pkg::NUM_CH; c++) begin
        rem[c] <= sums[c*SUM_W +: SUM_W];
      end
    end else if (busy) begin
      for (int c = 0; c < rbds_pkg::NUM_CH; c++) begin
        if (WIDE_W'(rem[c]) >= shifted) begin
          rem[c] <= rem[c] - shifted[SUM_W-1:0];
          quot[c*rbds_pkg::CH_W + 32'(bitpos)] <= 1'b1;
        end else begin
          quot[c*rbds_pkg::CH_W + 32'(bitpos)] <= 1'b0;
        end
      end
    end
  end

endmodule

[rtl/rgba_box_downsample.sv]
// rgba_box_downsample: top level of the RGBA8888 box-filter downsampler.
// Uses rbds_pkg, rbds_line_store and rbds_div.
//
// Pixels arrive as a raster stream on s_*; with oversampling on, every
// block_size x block_size square is averaged per channel (truncating) into one
// pixel on m_*, with m_tlast on the last pixel of each output row. Column
// partial sums live in a single-port-read line store of MAX_WIDTH entries that
// is read when a beat is taken and written back in the cycle after. A
// pass-through beat goes straight to the output register; an averaging beat
// is read and written back, and the beat that finishes a square also takes
// eight quotient bits of the shared four-lane divider and a result load.
// Only one beat is in flight; a finished pixel waits in the output register
// and the next beat is taken as that register drains. Line store contents
// need no clearing: the first pixel of every square overwrites its entry.
module rgba_box_downsample #(
  parameter int MAX_WIDTH = 4096,
  parameter int MAX_BLOCK = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  // configuration
  input  logic                              cfg_we,
  input  logic [rbds_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rbds_pkg::CFG_DATA_W-1:0]   cfg_data,
  // input stream
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [rbds_pkg::PIX_W-1:0]        s_tdata,   // [31:0] pixel_in
  input  logic                              s_tuser,   // [0] frame_start
  // output stream
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [rbds_pkg::PIX_W-1:0]        m_tdata,   // [31:0] pixel_out
  output logic                              m_tlast    // row_end
);

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int CW    = COL_W + 1;          // holds MAX_WIDTH itself
  localparam int SUB_W = $clog2(MAX_BLOCK);
  localparam int BW    = SUB_W + 1;          // holds MAX_BLOCK itself
  localparam int N_W   = 2 * BW;
  localparam int SUM_W = rbds_pkg::CH_W + 2 * SUB_W;
  localparam int ENT_W = rbds_pkg::NUM_CH * SUM_W;

  // Configuration registers
  logic                            oversample;
  logic [rbds_pkg::BLK_REG_W-1:0]  block_size;
  logic [rbds_pkg::WID_REG_W-1:0]  out_width;

  always_ff @(posedge clk) begin
    if (rst) begin
      oversample <= 1'b0;
      block_size <= rbds_pkg::BLOCK_RESET;
      out_width  <= rbds_pkg::WIDTH_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        rbds_pkg::CFG_OVERSAMPLE: oversample <= cfg_data[0];
        rbds_pkg::CFG_BLOCK_SIZE: block_size <= cfg_data[rbds_pkg::BLK_REG_W-1:0];
        rbds_pkg::CFG_OUT_WIDTH:  out_width  <= cfg_data[rbds_pkg::WID_REG_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective block and width: zero reads as one, large values saturate.
  logic [BW-1:0]  eff_b;
  logic [CW-1:0]  eff_w;
  logic [N_W-1:0] blk_area;

  always_comb begin
    if (block_size == '0) eff_b = BW'(1);
    else if (32'(block_size) > 32'(MAX_BLOCK)) eff_b = BW'(MAX_BLOCK);
    else eff_b = BW'(block_size);
    if (out_width == '0) eff_w = CW'(1);
    else if (32'(out_width) > 32'(MAX_WIDTH)) eff_w = CW'(MAX_WIDTH);
    else eff_w = CW'(out_width);
  end

  assign blk_area = N_W'(eff_b) * N_W'(eff_b);

  // Position counters
  logic [COL_W-1:0] out_column, out_column_next;
  logic [SUB_W-1:0] sub_column, sub_column_next;
  logic [SUB_W-1:0] sub_row, sub_row_next;

  logic [CW-1:0] col0, col1;
  logic [BW-1:0] sc0, sr0, sc1, sr1;
  logic          is_first, is_emit, is_row_end;

  always_comb begin
    col0 = s_tuser ? '0 : CW'(out_column);
    if (col0 >= eff_w) col0 = '0;
    sc0 = s_tuser ? '0 : BW'(sub_column);
    if (sc0 >= eff_b) sc0 = '0;
    sr0 = s_tuser ? '0 : BW'(sub_row);
    if (sr0 >= eff_b) sr0 = '0;

    is_first   = (sr0 == '0) && (sc0 == '0);
    is_emit    = (sr0 == eff_b - BW'(1)) && (sc0 == eff_b - BW'(1));
    is_row_end = (col0 == eff_w - CW'(1));

    col1 = col0;
    sc1  = sc0 + BW'(1);
    sr1  = sr0;
    if (!oversample) begin
      sc1  = '0;
      sr1  = '0;
      col1 = col0 + CW'(1);
      if (col1 >= eff_w) col1 = '0;
    end else if (sc1 >= eff_b) begin
      sc1  = '0;
      col1 = col0 + CW'(1);
      if (col1 >= eff_w) begin
        col1 = '0;
        sr1  = sr0 + BW'(1);
        if (sr1 >= eff_b) sr1 = '0;
      end
    end
    out_column_next = col1[COL_W-1:0];
    sub_column_next = sc1[SUB_W-1:0];
    sub_row_next    = sr1[SUB_W-1:0];
  end

  logic accept;
  assign accept = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_column <= '0;
      sub_column <= '0;
      sub_row    <= '0;
    end else if (accept) begin
      out_column <= out_column_next;
      sub_column <= sub_column_next;
      sub_row    <= sub_row_next;
    end
  end

  // Beat held across the read-modify-write
  logic [rbds_pkg::PIX_W-1:0] hold_pix;
  logic [COL_W-1:0]           hold_addr;
  logic                       hold_first, hold_emit, hold_last;

  always_ff @(posedge clk) begin
    if (accept) begin
      hold_pix   <= s_tdata;
      hold_addr  <= col0[COL_W-1:0];
      hold_first <= is_first;
      hold_emit  <= is_emit;
      hold_last  <= is_row_end;
    end
  end

  // Line store and read-modify-write
  rbds_pkg::state_t state, state_next;
  logic             st_rd, st_wr;
  logic [ENT_W-1:0] rd_data, sum_new;

  always_comb begin
    for (int c = 0; c < rbds_pkg::NUM_CH; c++) begin
      // channel 0 is alpha in the top byte
      sum_new[c*SUM_W +: SUM_W] =
          SUM_W'(hold_pix[(rbds_pkg::NUM_CH-1-c)*rbds_pkg::CH_W +: rbds_pkg::CH_W])
          + (hold_first ? '0 : rd_data[c*SUM_W +: SUM_W]);
    end
  end

  rbds_line_store #(
    .DEPTH (MAX_WIDTH),
    .DATA_W(ENT_W)
  ) u_store (
    .clk    (clk),
    .wr_en  (st_wr),
    .wr_addr(hold_addr),
    .wr_data(sum_new),
    .rd_en  (st_rd),
    .rd_addr(col0[COL_W-1:0]),
    .rd_data(rd_data)
  );

  // Divider
  logic div_start, div_done;
  logic [rbds_pkg::NUM_CH*rbds_pkg::CH_W-1:0] quot;

  rbds_div #(
    .SUM_W(SUM_W),
    .N_W  (N_W)
  ) u_div (
    .clk    (clk),
    .rst    (rst),
    .start  (div_start),
    .sums   (sum_new),
    .divisor(blk_area),
    .done   (div_done),
    .quot   (quot)
  );

  // Controller
  always_ff @(posedge clk) begin
    if (rst) state <= rbds_pkg::ST_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      rbds_pkg::ST_IDLE: begin
        if (accept && oversample) state_next = rbds_pkg::ST_RMW;
      end
      rbds_pkg::ST_RMW: begin
        state_next = hold_emit ? rbds_pkg::ST_DIV : rbds_pkg::ST_IDLE;
      end
      rbds_pkg::ST_DIV: begin
        if (div_done) state_next = rbds_pkg::ST_IDLE;
      end
      default: state_next = rbds_pkg::ST_IDLE;
    endcase
  end

  logic load_pass, load_avg;

  always_comb begin
    s_tready  = 1'b0;
    st_rd     = 1'b0;
    st_wr     = 1'b0;
    div_start = 1'b0;
    load_pass = 1'b0;
    load_avg  = 1'b0;
    case (state)
      rbds_pkg::ST_IDLE: begin
        s_tready  = !m_tvalid || m_tready;
        st_rd     = accept && oversample;
        load_pass = accept && !oversample;
      end
      rbds_pkg::ST_RMW: begin
        st_wr     = 1'b1;
        div_start = hold_emit;
      end
      rbds_pkg::ST_DIV: begin
        load_avg = div_done;
      end
      default: ;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_pass || load_avg) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_pass) begin
      m_tdata <= s_tdata;
      m_tlast <= is_row_end;
    end else if (load_avg) begin
      for (int c = 0; c < rbds_pkg::NUM_CH; c++) begin
        m_tdata[(rbds_pkg::NUM_CH-1-c)*rbds_pkg::CH_W +: rbds_pkg::CH_W] <=
            quot[c*rbds_pkg::CH_W +: rbds_pkg::CH_W];
      end
      m_tlast <= hold_last;
    end
  end

  // Checks
  a_busy_no_out: assert property (@(posedge clk) disable iff (rst)
    state != rbds_pkg::ST_IDLE |-> !m_tvalid)
    else $error("output register occupied while a beat is in flight");

  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> state == rbds_pkg::ST_IDLE)
    else $error("input taken while not idle");

  a_avg_out: assert property (@(posedge clk) disable iff (rst)
    state == rbds_pkg::ST_DIV && div_done |=> m_tvalid)
    else $error("finished average not presented");

  a_div_after_emit: assert property (@(posedge clk) disable iff (rst)
    state == rbds_pkg::ST_RMW && hold_emit |=> state == rbds_pkg::ST_DIV)
    else $error("square end did not start the divider");

endmodule
